// File: src/egc_pkg.sv
// Shared types, constants and the arctangent table for the gravity compensation block.
// No dependencies; every other file imports this package.
package egc_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int ANGLE_W      = 16;
  localparam int GRAV_W       = 11;
  localparam int CORDIC_STEPS = 18;
  localparam int TRIG_W       = 16;
  localparam int ROT_W        = SAMPLE_W + 4;
  localparam int PROD_W       = TRIG_W + ROT_W;

  localparam logic [GRAV_W-1:0]    GRAV_RESET = 11'd1255;
  localparam logic signed [31:0]   CORDIC_K   = 32'sd652032874;

  typedef logic signed [31:0] cw_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic signed [ANGLE_W-1:0]  roll_angle;
    logic signed [ANGLE_W-1:0]  pitch_angle;
    logic signed [ANGLE_W-1:0]  yaw_angle;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] linear_x;
    logic signed [SAMPLE_W-1:0] linear_y;
    logic signed [SAMPLE_W-1:0] linear_z;
    logic                       clipped;
  } out_t;

  // State handed along the CORDIC row: sample plus one rotator per angle
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] ax;
    logic signed [SAMPLE_W-1:0] ay;
    logic signed [SAMPLE_W-1:0] az;
    logic [2:0]                 neg;
    cw_t [2:0]                  cx;
    cw_t [2:0]                  cy;
    cw_t [2:0]                  cz;
  } cord_t;

  // Sample with sine and cosine of roll, pitch and yaw in Q1.14
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] ax;
    logic signed [SAMPLE_W-1:0] ay;
    logic signed [SAMPLE_W-1:0] az;
    logic [2:0][TRIG_W-1:0]     c;
    logic [2:0][TRIG_W-1:0]     s;
  } post_t;

  // Arctangent of 2^-step, 2^32 per turn
  function automatic logic [31:0] atan_turn(input int step);
    logic [31:0] r;
    unique case (step)
      0:       r = 32'h20000000;
      1:       r = 32'h12E4051E;
      2:       r = 32'h09FB385B;
      3:       r = 32'h051111D4;
      4:       r = 32'h028B0D43;
      5:       r = 32'h0145D7E1;
      6:       r = 32'h00A2F61E;
      7:       r = 32'h00517C55;
      8:       r = 32'h0028BE53;
      9:       r = 32'h00145F2F;
      10:      r = 32'h000A2F98;
      11:      r = 32'h000517CC;
      12:      r = 32'h00028BE6;
      13:      r = 32'h000145F3;
      14:      r = 32'h0000A2FA;
      15:      r = 32'h0000517D;
      16:      r = 32'h000028BE;
      17:      r = 32'h0000145F;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// File: src/egc_cordic_cell.sv
// One CORDIC micro-rotation for all three angles, registered.
// Depends on egc_pkg.
module egc_cordic_cell import egc_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  en,
  input  cord_t d,
  output cord_t q
);

  cord_t q_nxt;

  // rotate towards zero residual angle
  always_comb begin
    logic signed [31:0] xi, yi, zi, dx, dy, at;
    q_nxt = d;
    at    = $signed(atan_turn(STEP));
    for (int j = 0; j < 3; j++) begin
      xi = d.cx[j];
      yi = d.cy[j];
      zi = d.cz[j];
      dx = yi >>> STEP;
      dy = xi >>> STEP;
      if (!zi[31]) begin
        q_nxt.cx[j] = xi - dx;
        q_nxt.cy[j] = yi + dy;
        q_nxt.cz[j] = zi - at;
      end else begin
        q_nxt.cx[j] = xi + dx;
        q_nxt.cy[j] = yi - dy;
        q_nxt.cz[j] = zi + at;
      end
    end
  end

  // advance with the row
  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_nxt;
    end
  end

endmodule

// File: src/egc_rot_cell.sv
// Plane rotation of a component pair by Q1.14 sine and cosine, two register stages.
// Depends on egc_pkg.
module egc_rot_cell import egc_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [TRIG_W-1:0] c,
  input  logic signed [TRIG_W-1:0] s,
  input  logic signed [ROT_W-1:0] p,
  input  logic signed [ROT_W-1:0] qv,
  output logic signed [ROT_W-1:0] a,
  output logic signed [ROT_W-1:0] b
);

  localparam int SUM_W = PROD_W + 1;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(8192);

  logic signed [PROD_W-1:0] m0_r, m1_r, m2_r, m3_r;
  logic signed [PROD_W-1:0] m0_nxt, m1_nxt, m2_nxt, m3_nxt;
  logic signed [SUM_W-1:0]  sa, sb;
  logic signed [ROT_W-1:0]  a_nxt, b_nxt;

  // form the four products
  assign m0_nxt = c * p;
  assign m1_nxt = s * qv;
  assign m2_nxt = s * p;
  assign m3_nxt = c * qv;

  // combine and round half up back to Q9.7
  assign sa    = SUM_W'(m0_r) - SUM_W'(m1_r) + ROUND_HALF;
  assign sb    = SUM_W'(m2_r) + SUM_W'(m3_r) + ROUND_HALF;
  assign a_nxt = ROT_W'(sa >>> 14);
  assign b_nxt = ROT_W'(sb >>> 14);

  always_ff @(posedge clk) begin
    if (en) begin
      m0_r <= m0_nxt;
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
      m3_r <= m3_nxt;
      a    <= a_nxt;
      b    <= b_nxt;
    end
  end

endmodule

// File: src/euler_gravity_compensation.sv
// Top level: CORDIC row, three plane rotations, gravity removal and output buffering.
// Depends on egc_pkg, egc_cordic_cell and egc_rot_cell.
//
// Usage
//   Input channel in_valid / in_stall / in_data carries one sample with roll, pitch
//   and yaw; a transaction completes when in_valid is high and in_stall low.
//   Output channel out_valid / out_stall / out_data returns one world-frame result
//   per sample, in order, with clipped set when any component saturated.
//   cfg_valid / cfg_ready / cfg_data writes the gravity magnitude (Q9.7); cfg_ready
//   is always high. Write it only while the block is idle.
// Stages
//   From input transaction to result on the output register: 18 CORDIC cells, one
//   sine/cosine rounding stage, two stages for each of the three rotations, and the
//   output register. One sample is accepted per cycle while in_stall is low.
// Stall
//   When out_stall holds a result, one more result drops into a skid register and
//   the whole row then freezes with in_stall high until the skid empties.
// Reset
//   rst_n low clears all valid flags and loads gravity with 1255 (9.805 m/s^2).
module euler_gravity_compensation import egc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [GRAV_W-1:0] cfg_data
);

  localparam int NSTAGE = CORDIC_STEPS + 7;
  localparam int ZW     = ROT_W + 1;
  localparam logic signed [ZW-1:0] SAT_HI = ZW'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [ZW-1:0] SAT_LO = -ZW'(1 << (SAMPLE_W - 1));

  logic [GRAV_W-1:0] grav_r;
  logic [NSTAGE-1:0] v_r;
  logic              en;
  logic              take;

  cord_t             cs [0:CORDIC_STEPS];
  post_t             post_nxt;
  post_t             q18_r, p19_r, p20_r, p21_r, p22_r;
  logic signed [ROT_W-1:0] roll_y, roll_z, pit_x, pit_z, yaw_x, yaw_y;
  logic signed [ROT_W-1:0] y21_r, y22_r, z23_r, z24_r;
  logic signed [TRIG_W-1:0] pitch_ns;

  out_t              fin;
  out_t              o_r, s_r;
  logic              ov_r, sv_r;

  // cosine or sine in Q2.30 to Q1.14, with quadrant sign restored
  function automatic logic signed [TRIG_W-1:0] to_q14(input logic signed [31:0] v,
                                                       input logic ngt);
    logic signed [32:0] w;
    logic signed [16:0] r;
    w = {v[31], v};
    if (ngt) begin
      w = -w;
    end
    w = w + 33'sd32768;
    r = 17'(w >>> 16);
    if (r > 17'sd16384) begin
      r = 17'sd16384;
    end else if (r < -17'sd16384) begin
      r = -17'sd16384;
    end
    return TRIG_W'(r);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat(input logic signed [ZW-1:0] v,
                                                      output logic clip);
    logic signed [SAMPLE_W-1:0] r;
    clip = 1'b0;
    r    = SAMPLE_W'(v);
    if (v > SAT_HI) begin
      clip = 1'b1;
      r    = SAMPLE_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      clip = 1'b1;
      r    = SAMPLE_W'(SAT_LO);
    end
    return r;
  endfunction

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= GRAV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      grav_r <= cfg_data;
    end
  end

  // row advances while the skid register is empty
  assign en       = !sv_r;
  assign in_stall = !en;
  assign take     = en && v_r[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTAGE-2:0], in_valid};
    end
  end

  // reduce angles to the right half plane and seed the rotators
  always_comb begin
    logic [2:0][ANGLE_W-1:0] ang;
    logic [31:0]             u;
    logic                    ngt;
    ang   = {in_data.yaw_angle, in_data.pitch_angle, in_data.roll_angle};
    cs[0] = '0;
    cs[0].ax = in_data.accel_x;
    cs[0].ay = in_data.accel_y;
    cs[0].az = in_data.accel_z;
    for (int j = 0; j < 3; j++) begin
      u  = {ang[j], {(32 - ANGLE_W){1'b0}}};
      ngt = u[31] ^ u[30];
      cs[0].neg[j] = ngt;
      cs[0].cz[j]  = ngt ? {~u[31], u[30:0]} : u;
      cs[0].cx[j]  = CORDIC_K;
      cs[0].cy[j]  = '0;
    end
  end

  // CORDIC row, one cell per micro-rotation
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    egc_cordic_cell #(.STEP(g)) u_cell (
      .clk (clk),
      .en  (en),
      .d   (cs[g]),
      .q   (cs[g+1])
    );
  end

  // round sine and cosine
  always_comb begin
    post_nxt    = '0;
    post_nxt.ax = cs[CORDIC_STEPS].ax;
    post_nxt.ay = cs[CORDIC_STEPS].ay;
    post_nxt.az = cs[CORDIC_STEPS].az;
    for (int j = 0; j < 3; j++) begin
      post_nxt.c[j] = to_q14(cs[CORDIC_STEPS].cx[j], cs[CORDIC_STEPS].neg[j]);
      post_nxt.s[j] = to_q14(cs[CORDIC_STEPS].cy[j], cs[CORDIC_STEPS].neg[j]);
    end
  end

  // carry trig values and untouched components beside the rotations
  always_ff @(posedge clk) begin
    if (en) begin
      q18_r <= post_nxt;
      p19_r <= q18_r;
      p20_r <= p19_r;
      p21_r <= p20_r;
      p22_r <= p21_r;
      y21_r <= roll_y;
      y22_r <= y21_r;
      z23_r <= pit_z;
      z24_r <= z23_r;
    end
  end

  // roll: (y, z)
  egc_rot_cell u_roll (
    .clk (clk),
    .en  (en),
    .c   ($signed(q18_r.c[0])),
    .s   ($signed(q18_r.s[0])),
    .p   (ROT_W'(q18_r.ay)),
    .qv  (ROT_W'(q18_r.az)),
    .a   (roll_y),
    .b   (roll_z)
  );

  // pitch: (x, z) with the sine reversed
  assign pitch_ns = TRIG_W'(-$signed(p20_r.s[1]));

  egc_rot_cell u_pitch (
    .clk (clk),
    .en  (en),
    .c   ($signed(p20_r.c[1])),
    .s   (pitch_ns),
    .p   (ROT_W'(p20_r.ax)),
    .qv  (roll_z),
    .a   (pit_x),
    .b   (pit_z)
  );

  // yaw: (x, y)
  egc_rot_cell u_yaw (
    .clk (clk),
    .en  (en),
    .c   ($signed(p22_r.c[2])),
    .s   ($signed(p22_r.s[2])),
    .p   (pit_x),
    .qv  (y22_r),
    .a   (yaw_x),
    .b   (yaw_y)
  );

  // remove gravity and saturate
  always_comb begin
    logic cx, cy, cz;
    logic signed [ZW-1:0] zg;
    zg           = ZW'(z24_r) - ZW'($signed({1'b0, grav_r}));
    fin.linear_x = sat(ZW'(yaw_x), cx);
    fin.linear_y = sat(ZW'(yaw_y), cy);
    fin.linear_z = sat(zg, cz);
    fin.clipped  = cx | cy | cz;
  end

  // output register with skid behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (!ov_r || !out_stall) begin
      if (sv_r) begin
        ov_r <= 1'b1;
        sv_r <= 1'b0;
      end else begin
        ov_r <= take;
      end
    end else if (take) begin
      sv_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov_r || !out_stall) begin
      o_r <= sv_r ? s_r : fin;
    end else if (take) begin
      s_r <= fin;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = o_r;

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Testbench for euler_gravity_compensation: directed and random samples checked against
// an in-bench fixed-point CORDIC rotation predictor. Depends on egc_pkg and the RTL.
module tb import egc_pkg::*;;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [GRAV_W-1:0] cfg_data = '0;

  logic [GRAV_W-1:0] gravity_q7;
  out_t              pending_linear[$];
  int                n_errors = 0;
  int                n_samples = 0;
  int                n_results = 0;
  int                n_clipped = 0;

  euler_gravity_compensation DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Floor shift of a signed 64-bit value
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // CORDIC sine and cosine rounded to Q1.14
  function automatic void trig_q14(logic [ANGLE_W-1:0] ang, output longint s,
                                   output longint c);
    logic [31:0] u;
    bit          flip;
    longint      x, y, z, dx, dy;
    u = {ang, 16'h0};
    flip = (u[31:30] == 2'b01) || (u[31:30] == 2'b10);
    if (flip) u = u + 32'h8000_0000;
    z = longint'($signed(u));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turn(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turn(i));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = floor_shr(x + 32768, 16);
    s = floor_shr(y + 32768, 16);
    if (c > 16384) c = 16384;
    if (c < -16384) c = -16384;
    if (s > 16384) s = 16384;
    if (s < -16384) s = -16384;
  endfunction

  function automatic longint blend(longint a, longint p, longint b, longint q);
    return floor_shr(a * p - b * q + 8192, 14);
  endfunction

  function automatic logic [SAMPLE_W-1:0] clamp16(longint v, inout logic clip);
    if (v > 32767) begin
      clip = 1'b1; return 16'sh7fff;
    end
    if (v < -32768) begin
      clip = 1'b1; return 16'sh8000;
    end
    return v[SAMPLE_W-1:0];
  endfunction

  // World-frame linear acceleration for one sample
  function automatic out_t world_linear(in_t smp, logic [GRAV_W-1:0] grav);
    longint x, y, z, s, c, t;
    out_t   r;
    logic   clip;
    clip = 1'b0;
    x = smp.accel_x;
    y = smp.accel_y;
    z = smp.accel_z;
    trig_q14(smp.roll_angle, s, c);
    t = blend(c, y, s, z);
    z = blend(s, y, -c, z);
    y = t;
    trig_q14(smp.pitch_angle, s, c);
    t = blend(c, x, -s, z);
    z = blend(c, z, s, x);
    x = t;
    trig_q14(smp.yaw_angle, s, c);
    t = blend(c, x, s, y);
    y = blend(s, x, -c, y);
    x = t;
    z -= longint'(grav);
    r.linear_x = clamp16(x, clip);
    r.linear_y = clamp16(y, clip);
    r.linear_z = clamp16(z, clip);
    r.clipped  = clip;
    return r;
  endfunction

  // Drop valid after the last transaction of a burst
  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  // Send one sample after a random gap; valid stays high across back-to-back items
  task automatic send_sample(in_t smp);
    int gap;
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= smp;
    pending_linear.push_back(world_linear(smp, gravity_q7));
    n_samples++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drain the pipe, then let the latency pass before touching the register
  task automatic wait_idle();
    release_input();
    while (pending_linear.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_gravity(logic [GRAV_W-1:0] g);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= g;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    gravity_q7 = g;
  endtask

  function automatic in_t rand_sample(bit big);
    in_t smp;
    smp = in_t'({$urandom, $urandom, $urandom});
    if (!big) begin
      smp.accel_x = $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
      smp.accel_y = $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
      smp.accel_z = $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
    end
    return smp;
  endfunction

  // Extremes of every field and the quadrant corners of the angles
  task automatic test_directed();
    logic signed [15:0] edges[8];
    in_t smp;
    edges = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff,
              16'sh4000, 16'shc000, 16'sh3fff, 16'sh2000};
    for (int k = 0; k < 8; k++) begin
      smp.accel_x = edges[k]; smp.accel_y = edges[(k + 3) % 8]; smp.accel_z = edges[(k + 5) % 8];
      smp.roll_angle = edges[(k + 1) % 8]; smp.pitch_angle = edges[(k + 2) % 8];
      smp.yaw_angle = edges[(k + 6) % 8];
      send_sample(smp);
    end
    // Rest at zero angles hits gravity subtraction, full-scale hits saturation
    smp = '0; smp.accel_z = 16'sd1255;
    send_sample(smp);
    smp = '0; smp.accel_z = 16'sh8000;
    send_sample(smp);
    smp = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh2000, 16'sh2000, 16'sh2000};
    send_sample(smp);
    smp = '{16'sh8000, 16'sh8000, 16'sh8000, 16'she000, 16'she000, 16'she000};
    send_sample(smp);
  endtask

  task automatic test_gravity_settings();
    logic [GRAV_W-1:0] settings[4];
    settings = '{11'd0, 11'd2047, 11'd1, 11'd1024};
    foreach (settings[k]) begin
      write_gravity(settings[k]);
      for (int n = 0; n < 40; n++) send_sample(rand_sample($urandom_range(0, 3) == 0));
    end
    write_gravity(GRAV_RESET);
  endtask

  task automatic test_random();
    for (int n = 0; n < 1500; n++) begin
      send_sample(rand_sample($urandom_range(0, 4) == 0));
      // Hold off until the pipe has emptied, once mid-run
      if (n == 700) begin
        release_input();
        while (pending_linear.size() != 0) @(posedge clk);
      end
    end
  endtask

  // Receiver: draw a wait for every result, with stretches of none
  initial begin
    int hold_n;
    forever begin
      hold_n = $urandom_range(0, 19);
      if (n_results % 200 < 50) hold_n = 0;
      if (hold_n > 0) begin
        out_stall <= 1'b1;
        repeat (hold_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_linear.size() == 0) begin
        $display("%0t: expected no result, actual %h", $time, out_data);
        n_errors++;
      end else begin
        want = pending_linear.pop_front();
        if (want.clipped) n_clipped++;
        if (out_data.linear_x !== want.linear_x)
          $display("%0t: linear_x expected %0d actual %0d", $time, want.linear_x,
                   out_data.linear_x);
        if (out_data.linear_y !== want.linear_y)
          $display("%0t: linear_y expected %0d actual %0d", $time, want.linear_y,
                   out_data.linear_y);
        if (out_data.linear_z !== want.linear_z)
          $display("%0t: linear_z expected %0d actual %0d", $time, want.linear_z,
                   out_data.linear_z);
        if (out_data.clipped !== want.clipped)
          $display("%0t: clipped expected %0b actual %0b", $time, want.clipped,
                   out_data.clipped);
        if (out_data !== want) n_errors++;
      end
    end
  end

  initial begin
    gravity_q7 = GRAV_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_gravity_settings();
    test_random();
    release_input();
    while (pending_linear.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d samples, checked %0d results (%0d saturated), gravity 0..2047.",
             n_samples, n_results, n_clipped);
    if (n_errors == 0 && pending_linear.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #3000000;
    $display("Timeout with %0d results outstanding", pending_linear.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
